FILE: rtl/wpm_pkg.sv
// Package with shared types, codes and helpers of the wildcard pattern matcher.
`timescale 1ns / 1ps

package wpm_pkg;

  // Default depth of the pattern store.
  localparam int unsigned PatternDepthDef = 64;

  // Fixed widths of the ports and of the match position.
  localparam int unsigned CmdW    = 2;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned SlotW   = 6;
  localparam int unsigned LenW    = 7;
  localparam int unsigned PosW    = 7;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDatW = 7;

  // Command codes of an input beat.
  localparam logic [CmdW-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CmdW-1:0] CMD_STRING = 2'd1;
  localparam logic [CmdW-1:0] CMD_END    = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_PATTERN_LENGTH = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_CASE_FOLD      = 1'd1;

  // The wildcard byte.
  localparam logic [ByteW-1:0] STAR_BYTE = 8'h2A;

  // Result of the shared compare unit.
  typedef struct packed {
    logic is_star;
    logic equal;
  } cmp_res_t;

  // Lowers ASCII A-Z when folding is enabled.
  function automatic logic [ByteW-1:0] fold_byte(input logic [ByteW-1:0] b, input logic en);
    logic [ByteW-1:0] r;
    r = b;
    if (en && (b >= 8'h41) && (b <= 8'h5A)) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

FILE: rtl/wpm_store.sv
// Pattern store: one write port and one registered read port.
`timescale 1ns / 1ps

module wpm_store #(
  parameter int unsigned PATTERN_DEPTH = wpm_pkg::PatternDepthDef,
  parameter int unsigned ADDR_W = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [ADDR_W-1:0]        waddr_i,
  input  logic [wpm_pkg::ByteW-1:0] wdata_i,
  input  logic                     re_i,
  input  logic [ADDR_W-1:0]        raddr_i,
  output logic [wpm_pkg::ByteW-1:0] rdata_o
);
  import wpm_pkg::*;

  logic [ByteW-1:0] mem_q [PATTERN_DEPTH];
  logic [ByteW-1:0] rdata_q;

  // Write side.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read side.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/wpm_cmp.sv
// Shared compare unit: folds both bytes and compares them, and spots the wildcard.
`timescale 1ns / 1ps

module wpm_cmp (
  input  logic [wpm_pkg::ByteW-1:0] pat_byte_i,
  input  logic [wpm_pkg::ByteW-1:0] str_byte_i,
  input  logic                      fold_en_i,
  output wpm_pkg::cmp_res_t         res_o
);
  import wpm_pkg::*;

  logic [ByteW-1:0] pat_f;
  logic [ByteW-1:0] str_f;

  // Fold both sides, then compare.
  always_comb begin
    pat_f         = fold_byte(pat_byte_i, fold_en_i);
    str_f         = fold_byte(str_byte_i, fold_en_i);
    res_o.is_star = (pat_f == STAR_BYTE);
    res_o.equal   = (pat_f == str_f);
  end

endmodule

FILE: rtl/wildcard_pattern_matcher_core.sv
// Top level of the wildcard pattern matcher: handshake, sequencer and match state.
`timescale 1ns / 1ps

// A load beat (cmd 0), an end-of-string beat (cmd 2) or an ignored beat is handled
// at acceptance, and the block stays idle. A string byte (cmd 1) walks the pattern
// position by position: ST_READ reads the store, then ST_EVAL evaluates the byte in
// the shared compare unit. A literal match or a skipped byte ends the walk; a star,
// a rewind to the last star or a byte that equals the one after a star sends it back
// to ST_READ. The single read port of the pattern store is why each position is read
// before it is evaluated. The block is not ready while a string byte is at work, nor
// while an earlier verdict waits and cannot be taken. The verdict of an end-of-string
// beat is registered and appears on matched_o in the cycle after its acceptance.
module wildcard_pattern_matcher_core #(
  parameter int unsigned PATTERN_DEPTH = wpm_pkg::PatternDepthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [wpm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [wpm_pkg::CfgDatW-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [wpm_pkg::CmdW-1:0]    cmd_i,
  input  logic [wpm_pkg::ByteW-1:0]   byte_value_i,
  input  logic [wpm_pkg::SlotW-1:0]   pattern_slot_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        matched_o
);
  import wpm_pkg::*;

  localparam int unsigned AddrW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_EVAL = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [LenW-1:0]  pattern_length_q;
  logic             case_fold_q;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [PosW-1:0]  star_pos_q, star_pos_d;
  logic             star_valid_q, star_valid_d;
  logic             skipping_q, skipping_d;
  logic             failed_q, failed_d;
  logic             absorbed_q, absorbed_d;
  logic [ByteW-1:0] str_q, str_d;
  logic             out_valid_q;
  logic             matched_q;

  logic [LenW-1:0]  eff_len;
  logic             pos_done;
  logic             next_done;
  logic             in_fire;
  logic             load_we;
  logic             rd_en;
  logic [ByteW-1:0] rd_data;
  cmp_res_t         cmp_res;

  // Effective pattern length: clamp to the store depth.
  assign eff_len   = (int'(pattern_length_q) > int'(PATTERN_DEPTH)) ?
                     LenW'(PATTERN_DEPTH) : pattern_length_q;
  assign pos_done  = (pos_q >= eff_len);
  assign next_done = (({1'b0, pos_q} + 8'd1) >= {1'b0, eff_len});

  // Handshake: take a beat when idle and the verdict slot can accept one.
  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign load_we    = in_fire && (cmd_i == CMD_LOAD) &&
                      (int'(pattern_slot_i) < int'(PATTERN_DEPTH));
  assign rd_en      = (state_q == ST_READ) && !pos_done;

  // Pattern store.
  wpm_store #(
    .PATTERN_DEPTH(PATTERN_DEPTH),
    .ADDR_W       (AddrW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (load_we),
    .waddr_i(AddrW'(pattern_slot_i)),
    .wdata_i(byte_value_i),
    .re_i   (rd_en),
    .raddr_i(AddrW'(pos_q)),
    .rdata_o(rd_data)
  );

  // Shared compare unit.
  wpm_cmp u_cmp (
    .pat_byte_i(rd_data),
    .str_byte_i(str_q),
    .fold_en_i (case_fold_q),
    .res_o     (cmp_res)
  );

  // Sequencer and match state update.
  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    star_pos_d   = star_pos_q;
    star_valid_d = star_valid_q;
    skipping_d   = skipping_q;
    failed_d     = failed_q;
    absorbed_d   = absorbed_q;
    str_d        = str_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (cmd_i == CMD_STRING) begin
            if (!failed_q && !absorbed_q) begin
              str_d   = byte_value_i;
              state_d = ST_READ;
            end
          end else if (cmd_i == CMD_END) begin
            pos_d        = '0;
            star_pos_d   = '0;
            star_valid_d = 1'b0;
            skipping_d   = 1'b0;
            failed_d     = 1'b0;
            absorbed_d   = 1'b0;
          end
        end
      end
      ST_READ: begin
        if (pos_done) begin
          failed_d = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (skipping_q) begin
          // Skip the byte unless it equals the byte after the star.
          if (!cmp_res.equal) begin
            state_d = ST_IDLE;
          end else begin
            skipping_d = 1'b0;
            state_d    = ST_READ;
          end
        end else if (cmp_res.is_star) begin
          // Remember the star and step past it.
          star_pos_d   = pos_q;
          star_valid_d = 1'b1;
          pos_d        = pos_q + 7'd1;
          if (next_done) begin
            absorbed_d = 1'b1;
            state_d    = ST_IDLE;
          end else begin
            skipping_d = 1'b1;
            state_d    = ST_READ;
          end
        end else if (!cmp_res.equal) begin
          // Rewind to the last star, or fail.
          if (star_valid_q) begin
            pos_d        = star_pos_q;
            star_valid_d = 1'b0;
            state_d      = ST_READ;
          end else begin
            failed_d = 1'b1;
            state_d  = ST_IDLE;
          end
        end else begin
          pos_d   = pos_q + 7'd1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pos_q        <= '0;
      star_pos_q   <= '0;
      star_valid_q <= 1'b0;
      skipping_q   <= 1'b0;
      failed_q     <= 1'b0;
      absorbed_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      pos_q        <= pos_d;
      star_pos_q   <= star_pos_d;
      star_valid_q <= star_valid_d;
      skipping_q   <= skipping_d;
      failed_q     <= failed_d;
      absorbed_q   <= absorbed_d;
    end
  end

  // The string byte under work needs no reset.
  always_ff @(posedge clk_i) begin
    str_q <= str_d;
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_length_q <= '0;
      case_fold_q      <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PATTERN_LENGTH: pattern_length_q <= cfg_wdata_i[LenW-1:0];
        CFG_CASE_FOLD:      case_fold_q      <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  // Verdict output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && (cmd_i == CMD_END)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && (cmd_i == CMD_END)) begin
      matched_q <= !failed_q && (absorbed_q || pos_done);
    end
  end

  assign out_valid_o = out_valid_q;
  assign matched_o   = matched_q;

  // A fresh verdict only follows an accepted end-of-string beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_fire && (cmd_i == CMD_END)))
    else $error("verdict raised without an end-of-string beat");

  // A match cannot both fail and absorb the rest of the string.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(failed_q && absorbed_q))
    else $error("failed and absorbed set together");

  // A remembered star always lies behind the current pattern position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    star_valid_q |-> (star_pos_q < pos_q))
    else $error("remembered star not behind pattern position");

  // A string byte that starts work always leaves the idle state next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (cmd_i == CMD_STRING) && !failed_q && !absorbed_q)
      |=> (state_q == ST_READ))
    else $error("string byte did not start a pattern step");

endmodule

FILE: tb/tb_wildcard_pattern_matcher_core.sv
// Self-checking testbench of the wildcard pattern matcher core, with a built-in predictor.
`timescale 1ns / 1ps
module tb_wildcard_pattern_matcher_core;
  import wpm_pkg::*;

  localparam int unsigned DEPTH       = PatternDepthDef;
  localparam int unsigned ITEMS       = 1550;
  localparam int unsigned SETTLE      = 40;
  localparam int unsigned STUCK_LIMIT = 2000;
  localparam int unsigned MAX_WAIT    = 10;

  // The one command code that the package leaves undefined.
  localparam logic [CmdW-1:0] CMD_NONE = 2'd3;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [ByteW-1:0] value;
    logic [SlotW-1:0] slot;
  } beat_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               cfg_we_i       = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i    = '0;
  logic [CfgDatW-1:0] cfg_wdata_i    = '0;
  logic               in_valid_i     = 1'b0;
  logic               in_ready_o;
  logic [CmdW-1:0]    cmd_i          = CMD_LOAD;
  logic [ByteW-1:0]   byte_value_i   = '0;
  logic [SlotW-1:0]   pattern_slot_i = '0;
  logic               out_valid_o;
  logic               out_ready_i    = 1'b0;
  logic               matched_o;

  // Predicted state of the matcher and its copy of the registers.
  logic [ByteW-1:0] pat_mem [DEPTH];
  logic [PosW-1:0]  cur_pos;
  logic [5:0]       star_at;
  logic             star_seen;
  logic             in_skip;
  logic             has_failed;
  logic             absorbed;
  logic [LenW-1:0]  cfg_len;
  logic             fold_on;

  // Pattern as the stimulus side has queued it, used to build matching strings.
  logic [ByteW-1:0] plan_pat [DEPTH];

  beat_t       beat_q[$];
  logic        verdict_q[$];
  beat_t       cur_beat;
  int unsigned sent_cnt     = 0;
  int unsigned fail_cnt     = 0;
  int unsigned send_gap     = 0;
  int unsigned recv_stall   = 0;
  int unsigned stuck_cycles = 0;
  bit          idle_on      = 1'b1;

  wildcard_pattern_matcher_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .byte_value_i   (byte_value_i),
    .pattern_slot_i (pattern_slot_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .matched_o      (matched_o)
  );

  // Free-running clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Lowers ASCII capitals when folding is on.
  function automatic logic [ByteW-1:0] lower(input logic [ByteW-1:0] b);
    if (fold_on && (b >= 8'h41) && (b <= 8'h5A)) begin
      return b + 8'h20;
    end
    return b;
  endfunction

  function automatic int unsigned active_len();
    return (cfg_len > DEPTH) ? DEPTH : cfg_len;
  endfunction

  // Advances the match by one string byte; a byte may walk several pattern positions.
  task automatic walk_string(input logic [ByteW-1:0] raw);
    logic [ByteW-1:0] c;
    logic [ByteW-1:0] p;
    int unsigned      lim;
    int unsigned      guard;
    bit               done;
    c    = lower(raw);
    lim  = active_len();
    done = has_failed || absorbed;
    for (guard = 0; (guard < 4 * DEPTH + 8) && !done; guard++) begin
      if (cur_pos >= lim) begin
        has_failed = 1'b1;
        done       = 1'b1;
      end else begin
        p = lower(pat_mem[cur_pos[SlotW-1:0]]);
        if (in_skip) begin
          // The star swallows bytes until one equals the next pattern byte.
          if (p != c) begin
            done = 1'b1;
          end else begin
            in_skip = 1'b0;
          end
        end else if (p == STAR_BYTE) begin
          star_at   = cur_pos[5:0];
          star_seen = 1'b1;
          cur_pos   = cur_pos + 1'b1;
          if (cur_pos >= lim) begin
            absorbed = 1'b1;
            done     = 1'b1;
          end else begin
            in_skip = 1'b1;
          end
        end else if (p != c) begin
          if (star_seen) begin
            cur_pos   = {1'b0, star_at};
            star_seen = 1'b0;
          end else begin
            has_failed = 1'b1;
            done       = 1'b1;
          end
        end else begin
          cur_pos = cur_pos + 1'b1;
          done    = 1'b1;
        end
      end
    end
  endtask

  // Applies one accepted input beat to the predicted state.
  task automatic predict_beat(input beat_t b);
    case (b.cmd)
      CMD_LOAD: begin
        if (b.slot < DEPTH) begin
          pat_mem[b.slot] = b.value;
        end
      end
      CMD_STRING: begin
        walk_string(b.value);
      end
      CMD_END: begin
        verdict_q.insert(verdict_q.size(),
                         !has_failed && (absorbed || (cur_pos >= active_len())));
        cur_pos    = '0;
        star_at    = '0;
        star_seen  = 1'b0;
        in_skip    = 1'b0;
        has_failed = 1'b0;
        absorbed   = 1'b0;
      end
      default: begin
      end
    endcase
  endtask

  // Input driver: presents queued beats, with a random gap after each one while idle_on is set.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      cmd_i          <= CMD_LOAD;
      byte_value_i   <= '0;
      pattern_slot_i <= '0;
      send_gap       = 0;
      cur_pos        = '0;
      star_at        = '0;
      star_seen      = 1'b0;
      in_skip        = 1'b0;
      has_failed     = 1'b0;
      absorbed       = 1'b0;
      cfg_len        = '0;
      fold_on        = 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_beat(cur_beat);
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (beat_q.size() > 0) begin
          cur_beat       = beat_q.pop_front();
          cmd_i          <= cur_beat.cmd;
          byte_value_i   <= cur_beat.value;
          pattern_slot_i <= cur_beat.slot;
          in_valid_i     <= 1'b1;
          send_gap       = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each verdict beat with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_stall  = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          $error("matched: no verdict expected, actual %0b", matched_o);
          fail_cnt++;
        end else if (verdict_q[0] !== matched_o) begin
          $error("matched: expected %0b, actual %0b", verdict_q[0], matched_o);
          fail_cnt++;
          void'(verdict_q.pop_front());
        end else begin
          void'(verdict_q.pop_front());
        end
        recv_stall = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no beat moves on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("tb_wildcard_pattern_matcher_core: errors");
        $finish;
      end
    end
  end

  // Draws a byte biased toward letters of both cases and the wildcard.
  function automatic logic [ByteW-1:0] pick_sym();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r < 3) begin
      return ByteW'(8'h61 + r);
    end
    if (r < 6) begin
      return ByteW'(8'h41 + (r - 3));
    end
    if (r < 8) begin
      return STAR_BYTE;
    end
    return ByteW'($urandom_range(0, 255));
  endfunction

  task automatic add_beat(input logic [CmdW-1:0] cmd, input logic [ByteW-1:0] value,
                          input logic [SlotW-1:0] slot);
    beat_t b;
    b.cmd   = cmd;
    b.value = value;
    b.slot  = slot;
    if (cmd == CMD_LOAD) begin
      plan_pat[slot] = value;
    end
    if (cmd != CMD_NONE) begin
      sent_cnt++;
    end
    beat_q.insert(beat_q.size(), b);
  endtask

  task automatic push_text(input string s, input bit finish);
    int unsigned i;
    for (i = 0; i < s.len(); i++) begin
      add_beat(CMD_STRING, s[i], SlotW'($urandom_range(0, 63)));
    end
    if (finish) begin
      add_beat(CMD_END, ByteW'($urandom_range(0, 255)), SlotW'($urandom_range(0, 63)));
    end
  endtask

  // Queues one string: mostly derived from the pattern with small mutations, else noise.
  task automatic queue_string(input int unsigned eff, input bit finish);
    int unsigned      i;
    int unsigned      k;
    int unsigned      n;
    logic [ByteW-1:0] b;
    if ($urandom_range(0, 3) == 0) begin
      n = $urandom_range(0, 6);
      for (i = 0; i < n; i++) begin
        add_beat(CMD_STRING, pick_sym(), SlotW'($urandom_range(0, 63)));
      end
    end else begin
      for (i = 0; i < eff; i++) begin
        b = plan_pat[SlotW'(i)];
        if (b == STAR_BYTE) begin
          n = $urandom_range(0, 3);
          for (k = 0; k < n; k++) begin
            add_beat(CMD_STRING, pick_sym(), SlotW'($urandom_range(0, 63)));
          end
        end else if ($urandom_range(0, 15) == 0) begin
          add_beat(CMD_STRING, pick_sym(), SlotW'($urandom_range(0, 63)));
        end else if ($urandom_range(0, 31) != 0) begin
          // Flip the case of letters now and then to exercise folding.
          if (($urandom_range(0, 3) == 0) && (((b | 8'h20) >= 8'h61) && ((b | 8'h20) <= 8'h7A)))
          begin
            b = b ^ 8'h20;
          end
          add_beat(CMD_STRING, b, SlotW'($urandom_range(0, 63)));
        end
        // Occasional stray beat in the middle of the string.
        if ($urandom_range(0, 31) == 0) begin
          if ($urandom_range(0, 1) == 0) begin
            add_beat(CMD_NONE, ByteW'($urandom_range(0, 255)), SlotW'($urandom_range(0, 63)));
          end else begin
            add_beat(CMD_LOAD, pick_sym(), SlotW'($urandom_range(0, 63)));
          end
        end
      end
    end
    if (finish) begin
      add_beat(CMD_END, ByteW'($urandom_range(0, 255)), SlotW'($urandom_range(0, 63)));
    end
  endtask

  // Waits until every queued beat is sent and every verdict has come, then lets the core settle.
  task automatic settle();
    while ((beat_q.size() != 0) || in_valid_i || (verdict_q.size() != 0) || !in_ready_o) begin
      @(negedge clk_i);
    end
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_PATTERN_LENGTH) begin
      cfg_len = val[LenW-1:0];
    end else begin
      fold_on = val[0];
    end
    @(negedge clk_i);
  endtask

  task automatic apply_cfg(input logic [CfgDatW-1:0] len_word,
                           input logic [CfgDatW-1:0] fold_word);
    cfg_write(CFG_PATTERN_LENGTH, len_word);
    cfg_write(CFG_CASE_FOLD, fold_word);
  endtask

  // Stimulus: directed cases first, then random phases with new settings each.
  initial begin : main
    int unsigned     i;
    int unsigned     eff;
    int unsigned     n_str;
    int unsigned     r;
    logic [LenW-1:0] len_word;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty pattern against empty and non-empty strings, an unknown command, store loads.
    apply_cfg('0, '0);
    add_beat(CMD_END, 8'hFF, 6'h3F);
    add_beat(CMD_STRING, 8'h00, 6'h00);
    add_beat(CMD_END, 8'h00, 6'h00);
    add_beat(CMD_NONE, 8'hFF, 6'h3F);
    add_beat(CMD_LOAD, 8'hFF, 6'h3F);
    add_beat(CMD_LOAD, "A", 6'd0);
    add_beat(CMD_LOAD, STAR_BYTE, 6'd1);
    add_beat(CMD_LOAD, "c", 6'd2);
    add_beat(CMD_LOAD, STAR_BYTE, 6'd3);
    add_beat(CMD_LOAD, STAR_BYTE, 6'd4);

    // Folded compare, then a byte left over after the pattern is used up.
    settle();
    apply_cfg(7'd3, 7'd1);
    push_text("aXc", 1'b1);
    push_text("Abcc", 1'b1);

    // Trailing star reached and not reached.
    settle();
    apply_cfg(7'd2, 7'd0);
    push_text("A", 1'b1);
    push_text("Az", 1'b1);

    // Star followed by star, then a length change in the middle of a string.
    settle();
    apply_cfg(7'd5, 7'd0);
    push_text("Ac*", 1'b1);
    push_text("Aq", 1'b0);
    settle();
    apply_cfg(7'd3, 7'd0);
    push_text("c", 1'b1);

    // Fill the whole store so that any later length reads written entries only.
    for (i = 0; i < DEPTH; i++) begin
      add_beat(CMD_LOAD, pick_sym(), SlotW'(i));
    end

    while (sent_cnt < ITEMS) begin
      settle();
      idle_on = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 15);
      if (r == 0) begin
        len_word = '0;
      end else if (r == 1) begin
        len_word = LenW'(DEPTH);
      end else if (r == 2) begin
        len_word = LenW'($urandom_range(DEPTH + 1, 127));
      end else begin
        len_word = LenW'($urandom_range(1, 10));
      end
      apply_cfg(len_word, CfgDatW'($urandom_range(0, 127)));
      eff = (len_word > DEPTH) ? DEPTH : len_word;
      for (i = 0; i < eff; i++) begin
        add_beat(CMD_LOAD, pick_sym(), SlotW'(i));
      end
      n_str = $urandom_range(3, 8);
      for (i = 0; i < n_str; i++) begin
        queue_string(eff, 1'b1);
      end
      // Sometimes leave a string open across the next register change.
      if ($urandom_range(0, 3) == 0) begin
        queue_string(eff, 1'b0);
      end
    end

    settle();
    if (fail_cnt == 0) begin
      $display("tb_wildcard_pattern_matcher_core: clean");
    end else begin
      $display("tb_wildcard_pattern_matcher_core: errors");
    end
    $finish;
  end

endmodule
